FILE: design/lqc_pkg.sv
// Shared constants, codes and controller command type for the linked queue with cursor.
package lqc_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] K_PUSH   = 3'd0;
  localparam logic [KIND_W-1:0] K_POP    = 3'd1;
  localparam logic [KIND_W-1:0] K_FIRST  = 3'd2;
  localparam logic [KIND_W-1:0] K_LAST   = 3'd3;
  localparam logic [KIND_W-1:0] K_NEXT   = 3'd4;
  localparam logic [KIND_W-1:0] K_PREV   = 3'd5;
  localparam logic [KIND_W-1:0] K_REMOVE = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_END   = 2'd3;

  typedef struct packed {
    logic take;
    logic ph1;
    logic ph2;
    logic ph3;
    logic emit;
  } lqc_cmd_t;

endpackage

FILE: design/lqc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lqc_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/lqc_ctrl.sv
// Controller state machine: input/output handshake and phase sequencing.
module lqc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output lqc_pkg::lqc_cmd_t cmd
);

  import lqc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OP1  = 3'd1;
  localparam logic [2:0] S_OP2  = 3'd2;
  localparam logic [2:0] S_OP3  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_OP1;
        end
      end
      S_OP1: begin
        cmd.ph1   = 1'b1;
        state_nxt = S_OP2;
      end
      S_OP2: begin
        cmd.ph2   = 1'b1;
        state_nxt = S_OP3;
      end
      S_OP3: begin
        cmd.ph3   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: design/lqc_dp.sv
// Datapath: node pool memories, list pointers, free list and result registers.
module lqc_dp #(
  parameter int DEPTH      = lqc_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = lqc_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lqc_pkg::lqc_cmd_t             cmd,
  input  logic [lqc_pkg::KIND_W-1:0]    in_kind,
  input  logic [DATA_WIDTH-1:0]         in_value,
  output logic [lqc_pkg::STATUS_W-1:0]  out_status,
  output logic [DATA_WIDTH-1:0]         out_popped_value,
  output logic                          out_cursor_valid,
  output logic [DATA_WIDTH-1:0]         out_cursor_value
);

  import lqc_pkg::*;

  localparam int IW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam logic [IW-1:0] NIL = IW'(DEPTH);

  function automatic logic live(input logic [IW-1:0] i);
    return i < NIL;
  endfunction

  logic [KIND_W-1:0]     kind_r;
  logic [DATA_WIDTH-1:0] value_r;
  logic [IW-1:0]         node_r;

  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] free_r, free_nxt;
  logic [IW-1:0] hwm_r, hwm_nxt;
  logic          fwd_r, fwd_nxt;

  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [DATA_WIDTH-1:0] popped_r, popped_nxt;
  logic [DATA_WIDTH-1:0] cval_r, cval_nxt;

  logic [STATUS_W-1:0]   out_status_r;
  logic [DATA_WIDTH-1:0] out_popped_r;
  logic                  out_cvalid_r;
  logic [DATA_WIDTH-1:0] out_cvalue_r;

  logic                  nx_we, pv_we, dt_we;
  logic [IW-1:0]         nx_wa, nx_wd, pv_wa, pv_wd, dt_ra;
  logic [IW-1:0]         nx_rd, pv_rd;
  logic [DATA_WIDTH-1:0] dt_rd;
  logic [IW-1:0]         sel_idx;

  lqc_ram #(.W(IW), .D(DEPTH)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_wa[AW-1:0]),
    .wdata (nx_wd),
    .raddr (node_r[AW-1:0]),
    .rdata (nx_rd)
  );

  lqc_ram #(.W(IW), .D(DEPTH)) u_prev_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_wa[AW-1:0]),
    .wdata (pv_wd),
    .raddr (node_r[AW-1:0]),
    .rdata (pv_rd)
  );

  lqc_ram #(.W(DATA_WIDTH), .D(DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (dt_we),
    .waddr (node_r[AW-1:0]),
    .wdata (value_r),
    .raddr (dt_ra[AW-1:0]),
    .rdata (dt_rd)
  );

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cur_nxt    = cur_r;
    fwd_nxt    = fwd_r;
    free_nxt   = free_r;
    hwm_nxt    = hwm_r;
    status_nxt = status_r;
    popped_nxt = popped_r;
    cval_nxt   = cval_r;
    nx_we      = 1'b0;
    nx_wa      = node_r;
    nx_wd      = NIL;
    pv_we      = 1'b0;
    pv_wa      = node_r;
    pv_wd      = NIL;
    dt_we      = 1'b0;
    sel_idx    = fwd_r ? head_r : tail_r;

    if (cmd.take) begin
      status_nxt = ST_OK;
      popped_nxt = '0;
    end

    // phase 1: link reads are in flight; push links the new node to the tail
    if (cmd.ph1 && kind_r == K_PUSH && live(node_r)) begin
      dt_we = 1'b1;
      pv_we = 1'b1;
      pv_wd = tail_r;
      if (live(tail_r)) begin
        nx_we = 1'b1;
        nx_wa = tail_r;
        nx_wd = node_r;
      end
    end

    // phase 2: links of the node are available
    if (cmd.ph2) begin
      unique case (kind_r)
        K_PUSH: begin
          cur_nxt = NIL;
          if (!live(node_r)) begin
            status_nxt = ST_FULL;
          end else begin
            if (node_r == hwm_r) begin
              free_nxt = node_r + IW'(1);
              hwm_nxt  = hwm_r + IW'(1);
            end else begin
              free_nxt = nx_rd;
            end
            nx_we = 1'b1;
            nx_wa = node_r;
            nx_wd = NIL;
            if (!live(tail_r)) begin
              head_nxt = node_r;
            end
            tail_nxt = node_r;
          end
        end
        K_POP: begin
          cur_nxt = NIL;
          if (!live(node_r)) begin
            status_nxt = ST_EMPTY;
          end else begin
            head_nxt   = nx_rd;
            popped_nxt = dt_rd;
            if (live(nx_rd)) begin
              pv_we = 1'b1;
              pv_wa = nx_rd;
              pv_wd = NIL;
            end else begin
              tail_nxt = NIL;
            end
          end
        end
        K_FIRST, K_LAST: begin
          fwd_nxt = (kind_r == K_FIRST);
          sel_idx = (kind_r == K_FIRST) ? head_r : tail_r;
          if (live(sel_idx)) begin
            cur_nxt = sel_idx;
          end else begin
            cur_nxt    = NIL;
            status_nxt = ST_EMPTY;
          end
        end
        K_NEXT, K_PREV: begin
          fwd_nxt = (kind_r == K_NEXT);
          if (!live(cur_r)) begin
            status_nxt = ST_END;
          end else begin
            cur_nxt = (kind_r == K_NEXT) ? nx_rd : pv_rd;
          end
        end
        K_REMOVE: begin
          if (!live(node_r)) begin
            status_nxt = ST_EMPTY;
          end else begin
            if (live(pv_rd) && live(nx_rd)) begin
              nx_we = 1'b1;
              nx_wa = pv_rd;
              nx_wd = nx_rd;
              pv_we = 1'b1;
              pv_wa = nx_rd;
              pv_wd = pv_rd;
            end else if (node_r == head_r && node_r != tail_r) begin
              head_nxt = nx_rd;
              if (live(nx_rd)) begin
                pv_we = 1'b1;
                pv_wa = nx_rd;
                pv_wd = NIL;
              end
            end else if (node_r != head_r && node_r == tail_r) begin
              tail_nxt = pv_rd;
              if (live(pv_rd)) begin
                nx_we = 1'b1;
                nx_wa = pv_rd;
                nx_wd = NIL;
              end
            end else begin
              head_nxt = NIL;
              tail_nxt = NIL;
            end
            cur_nxt = fwd_r ? pv_rd : nx_rd;
          end
        end
        default: ;
      endcase
    end

    // phase 3: cursor data arrives; freed node goes to the front of the free list
    if (cmd.ph3) begin
      cval_nxt = dt_rd;
      if ((kind_r == K_POP || kind_r == K_REMOVE) && live(node_r)) begin
        nx_we    = 1'b1;
        nx_wa    = node_r;
        nx_wd    = free_r;
        free_nxt = node_r;
      end
    end
  end

  assign dt_ra = cmd.ph2 ? cur_nxt : node_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= NIL;
      tail_r <= NIL;
      cur_r  <= NIL;
      fwd_r  <= 1'b1;
      free_r <= '0;
      hwm_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cur_r  <= cur_nxt;
      fwd_r  <= fwd_nxt;
      free_r <= free_nxt;
      hwm_r  <= hwm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind_r  <= in_kind;
      value_r <= in_value;
      if (in_kind == K_PUSH) begin
        node_r <= free_r;
      end else if (in_kind == K_POP) begin
        node_r <= head_r;
      end else begin
        node_r <= cur_r;
      end
    end
    status_r <= status_nxt;
    popped_r <= popped_nxt;
    cval_r   <= cval_nxt;
    if (cmd.emit) begin
      out_status_r <= status_r;
      out_popped_r <= popped_r;
      out_cvalid_r <= live(cur_r);
      out_cvalue_r <= live(cur_r) ? cval_r : '0;
    end
  end

  assign out_status       = out_status_r;
  assign out_popped_value = out_popped_r;
  assign out_cursor_valid = out_cvalid_r;
  assign out_cursor_value = out_cvalue_r;

endmodule

FILE: design/linked_queue_with_cursor.sv
// Top level of the linked queue with cursor.
// A FIFO held as a doubly linked list in a pool of DEPTH nodes, with a cursor
// that can be set to either end, stepped forward or back, and used to remove
// the entry under it. Each accepted item yields exactly one result item with
// a status, the popped data and the data under the cursor. An item goes
// through a link read, a link update, a data read of the new cursor entry
// and the load of its result into the output register, which waits while
// that register holds a stalled result; the pool memories have registered
// reads. The next item is accepted in the cycle after the result is loaded,
// even while that result still waits at the output, so no new item is taken
// before the last one's result is loaded. Untouched pool nodes are tracked by
// a fill count, so no clearing pass follows reset.
module linked_queue_with_cursor #(
  parameter int DEPTH      = lqc_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = lqc_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lqc_pkg::KIND_W-1:0]   in_kind,
  input  logic [DATA_WIDTH-1:0]        in_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lqc_pkg::STATUS_W-1:0] out_status,
  output logic [DATA_WIDTH-1:0]        out_popped_value,
  output logic                         out_cursor_valid,
  output logic [DATA_WIDTH-1:0]        out_cursor_value
);

  import lqc_pkg::*;

  lqc_cmd_t cmd;

  lqc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  lqc_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_kind          (in_kind),
    .in_value         (in_value),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_cursor_valid (out_cursor_valid),
    .out_cursor_value (out_cursor_value)
  );

endmodule

FILE: verif/linked_queue_with_cursor_tb.sv
// Self-checking testbench for the linked queue with cursor: random and directed items.
`timescale 1ns / 1ps

module linked_queue_with_cursor_tb;
  import lqc_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int DW    = DATA_WIDTH_DEF;
  localparam int IW    = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] NIL = IW'(DEPTH);
  localparam logic [KIND_W-1:0] K_IDLE = 3'd7;
  localparam int RANDOM_ITEMS = 2000;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DW-1:0]       popped;
    logic                cursor_valid;
    logic [DW-1:0]       cursor_value;
  } lq_resp_t;

  class lq_scoreboard;
    logic [DW-1:0] node_data [DEPTH];
    logic [IW-1:0] fwd_link  [DEPTH];
    logic [IW-1:0] back_link [DEPTH];
    logic [IW-1:0] head, tail, cursor, free_top;
    bit            fwd_dir;
    lq_resp_t      expected_responses [$];
    int            errors;
    int            noted;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        node_data[i] = '0;
        back_link[i] = '0;
        fwd_link[i]  = IW'(i + 1);
      end
      head     = NIL;
      tail     = NIL;
      cursor   = NIL;
      free_top = '0;
      fwd_dir  = 1'b1;
      errors   = 0;
      noted    = 0;
    endfunction

    function bit is_node(logic [IW-1:0] i);
      return i < DEPTH;
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic [DW-1:0] value);
      lq_resp_t r;
      logic [IW-1:0] n, p, q;
      r = '0;
      noted++;
      case (kind)
        K_PUSH: begin
          cursor = NIL;
          if (!is_node(free_top)) begin
            r.status = ST_FULL;
          end else begin
            n            = free_top;
            free_top     = fwd_link[n];
            node_data[n] = value;
            fwd_link[n]  = NIL;
            back_link[n] = tail;
            if (is_node(tail)) fwd_link[tail] = n;
            else head = n;
            tail = n;
          end
        end
        K_POP: begin
          cursor = NIL;
          if (!is_node(head)) begin
            r.status = ST_EMPTY;
          end else begin
            n    = head;
            head = fwd_link[n];
            if (is_node(head)) back_link[head] = NIL;
            else tail = NIL;
            r.popped    = node_data[n];
            fwd_link[n] = free_top;
            free_top    = n;
          end
        end
        K_FIRST, K_LAST: begin
          fwd_dir = (kind == K_FIRST);
          cursor  = fwd_dir ? head : tail;
          if (!is_node(cursor)) begin
            cursor   = NIL;
            r.status = ST_EMPTY;
          end
        end
        K_NEXT, K_PREV: begin
          fwd_dir = (kind == K_NEXT);
          if (!is_node(cursor)) r.status = ST_END;
          else cursor = fwd_dir ? fwd_link[cursor] : back_link[cursor];
        end
        K_REMOVE: begin
          if (!is_node(cursor)) begin
            r.status = ST_EMPTY;
          end else begin
            n = cursor;
            p = back_link[n];
            q = fwd_link[n];
            if (is_node(p) && is_node(q)) begin
              fwd_link[p]  = q;
              back_link[q] = p;
            end else if (n == head && n != tail) begin
              head = q;
              if (is_node(q)) back_link[q] = NIL;
            end else if (n != head && n == tail) begin
              tail = p;
              if (is_node(p)) fwd_link[p] = NIL;
            end else begin
              head = NIL;
              tail = NIL;
            end
            cursor      = fwd_dir ? p : q;
            fwd_link[n] = free_top;
            free_top    = n;
          end
        end
        default: ;
      endcase
      if (is_node(cursor)) begin
        r.cursor_valid = 1'b1;
        r.cursor_value = node_data[cursor];
      end
      expected_responses.push_back(r);
    endfunction

    function void compare_field(string field, logic [DW-1:0] want, logic [DW-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t mismatch %s: expected %0h actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_response(logic [STATUS_W-1:0] status, logic [DW-1:0] popped,
                                 logic cursor_valid, logic [DW-1:0] cursor_value);
      lq_resp_t r;
      if (expected_responses.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual status %0h", $time, status);
        return;
      end
      r = expected_responses.pop_front();
      compare_field("status", DW'(r.status), DW'(status));
      compare_field("popped_value", r.popped, popped);
      compare_field("cursor_valid", DW'(r.cursor_valid), DW'(cursor_valid));
      compare_field("cursor_value", r.cursor_value, cursor_value);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [KIND_W-1:0]   in_kind;
  logic [DW-1:0]       in_value;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [DW-1:0]       out_popped_value;
  logic                out_cursor_valid;
  logic [DW-1:0]       out_cursor_value;

  lq_scoreboard sb = new();
  bit tx_calm;
  bit rx_calm;

  linked_queue_with_cursor dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_cursor_valid (out_cursor_valid),
    .out_cursor_value (out_cursor_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [DW-1:0] value);
    int gap;
    if ($urandom_range(0, 99) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    sb.note_request(kind, value);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_response(out_status, out_popped_value, out_cursor_valid, out_cursor_value);
  end

  // receiver: random stalls plus one long hold-off to back the block up
  initial begin : rx_proc
    int n;
    bit held;
    held = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held && sb.noted >= 700) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
      n = rx_calm ? 0 : idle_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  end

  initial begin : main_proc
    int mode, mode_left, r;
    logic [KIND_W-1:0] kind;
    logic [DW-1:0] value;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_kind   = K_PUSH;
    in_value  = '0;
    out_stall = 1'b0;
    tx_calm   = 1'b0;
    rx_calm   = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue and no cursor cases, unused kind
    send_request(K_POP, '0);
    send_request(K_FIRST, '0);
    send_request(K_LAST, '0);
    send_request(K_NEXT, '0);
    send_request(K_PREV, '0);
    send_request(K_REMOVE, '0);
    send_request(K_IDLE, '1);
    // fill the pool, then push into a full pool
    for (int i = 0; i < DEPTH; i++) begin
      value = (i == 0) ? '0 : (i == 1) ? '1 : DW'($urandom);
      send_request(K_PUSH, value);
    end
    send_request(K_PUSH, 32'h5a5a_a5a5);
    // walk off the tail, then pop with a successor present
    send_request(K_LAST, '0);
    send_request(K_NEXT, '0);
    send_request(K_POP, '0);

    mode = 0;
    mode_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      r = $urandom_range(0, 99);
      if (r == 0) kind = K_IDLE;
      else case (mode)
        0: kind = (r < 55) ? K_PUSH : (r < 65) ? K_POP : (r < 75) ? K_FIRST :
                  (r < 80) ? K_LAST : (r < 88) ? K_NEXT : (r < 93) ? K_PREV : K_REMOVE;
        1: kind = (r < 15) ? K_PUSH : (r < 65) ? K_POP : (r < 72) ? K_FIRST :
                  (r < 78) ? K_LAST : (r < 85) ? K_NEXT : (r < 90) ? K_PREV : K_REMOVE;
        default:
           kind = (r < 10) ? K_PUSH : (r < 20) ? K_POP : (r < 28) ? K_FIRST :
                  (r < 35) ? K_LAST : (r < 60) ? K_NEXT : (r < 85) ? K_PREV : K_REMOVE;
      endcase
      r = $urandom_range(0, 19);
      value = (r == 0) ? '0 : (r == 1) ? '1 : DW'($urandom);
      send_request(kind, value);
    end
    in_valid <= 1'b0;

    while (sb.expected_responses.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("timeout with %0d results outstanding", sb.expected_responses.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: linked_queue_with_cursor.f
design/lqc_pkg.sv
design/lqc_ram.sv
design/lqc_ctrl.sv
design/lqc_dp.sv
design/linked_queue_with_cursor.sv
verif/linked_queue_with_cursor_tb.sv
